/* rtl/btop_pkg.sv */
// shared types, constants and arithmetic helpers of the binomial option pricer
package btop_pkg;

	localparam int MAX_STEPS_DEF        = 255;
	localparam int PRICE_FRAC_BITS_DEF  = 16;
	localparam int FACTOR_FRAC_BITS_DEF = 30;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_STRIKE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BARRIER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UP        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UP_WGT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_WGT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd7;

	localparam logic [1:0] BAR_NONE     = 2'd0;
	localparam logic [1:0] BAR_UP_OUT   = 2'd1;
	localparam logic [1:0] BAR_DOWN_OUT = 2'd2;

	// option terms that every node cell needs
	typedef struct packed {
		logic [31:0] strike;
		logic [31:0] barrier;
		logic [31:0] down;
		logic [30:0] up_wgt;
		logic [30:0] down_wgt;
		logic        put;
		logic        american;
		logic [1:0]  bar;
	} cell_cfg_t;

	function automatic logic [31:0] payoff(input cell_cfg_t c, input logic [31:0] s);
		logic [31:0] r;
		r = '0;
		if (c.put) begin
			if (c.strike > s) r = c.strike - s;
		end else begin
			if (s > c.strike) r = s - c.strike;
		end
		return r;
	endfunction

	function automatic logic breached(input cell_cfg_t c, input logic [31:0] s);
		logic r;
		r = 1'b0;
		unique case (c.bar)
			BAR_UP_OUT:   r = (s >= c.barrier);
			BAR_DOWN_OUT: r = (s <= c.barrier);
			default:      r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/btop_mul.sv */
// shared price times factor multiplier with round to nearest and saturation
module btop_mul import btop_pkg::*; #(
	parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] f,
	output logic [31:0] y,
	output logic        sat
);
	localparam int PW = 64;
	logic [PW-1:0] prod_s1;
	logic [PW-1:0] r;

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(a) * PW'(f);
	end

	always_comb begin
		r = ((prod_s1 >> (FACTOR_FRAC_BITS - 1)) + PW'(1)) >> 1;
		sat = (r > PW'(32'hFFFF_FFFF));
		y = sat ? 32'hFFFF_FFFF : r[31:0];
	end
endmodule

/* rtl/btop_cell.sv */
// one lattice node cell: steps its price back and combines neighbor values
module btop_cell import btop_pkg::*; #(
	parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  cell_cfg_t   cfg,
	input  logic        load,
	input  logic [31:0] load_price,
	input  logic        step_mul,
	input  logic        step_upd,
	input  logic [31:0] nbr_value,
	output logic [31:0] value,
	output logic        sat
);
	localparam int PW = 64;
	logic [31:0]   price_q;
	logic [31:0]   value_q;
	logic [PW-1:0] pprod_s1, acc_s1;
	logic [PW-1:0] pr, ar;
	logic [31:0]   p, v, e;
	logic          psat, vsat;

	// step_mul: both products registered; step_upd: rounding and update
	always_ff @(posedge clk) begin
		if (step_mul) begin
			pprod_s1 <= PW'(price_q) * PW'(cfg.down);
			acc_s1   <= PW'(cfg.up_wgt) * PW'(value_q) + PW'(cfg.down_wgt) * PW'(nbr_value);
		end
	end

	always_comb begin
		pr = ((pprod_s1 >> (FACTOR_FRAC_BITS - 1)) + PW'(1)) >> 1;
		psat = (pr > PW'(32'hFFFF_FFFF));
		p = psat ? 32'hFFFF_FFFF : pr[31:0];
		ar = ((acc_s1 >> (FACTOR_FRAC_BITS - 1)) + PW'(1)) >> 1;
		vsat = (ar > PW'(32'hFFFF_FFFF));
		e = payoff(cfg, p);
		v = vsat ? 32'hFFFF_FFFF : ar[31:0];
		if (cfg.american && e > v) v = e;
		if (breached(cfg, p)) v = '0;
		sat = step_upd && (psat || (vsat && !breached(cfg, p)));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			price_q <= load_price;
			value_q <= breached(cfg, load_price) ? 32'd0 : payoff(cfg, load_price);
		end else if (step_upd) begin
			price_q <= p;
			value_q <= v;
		end
	end

	assign value = value_q;
endmodule

/* rtl/binomial_tree_option_pricer_core.sv */
// top level of the binomial lattice option pricer
// Prices one option per start pulse. From the accepting edge busy stays high
// through the down walk of the spot (n down products, then the load of node n),
// the up walk through the maturity row (two chained up products per node), the
// backward rounds (one multiply and one update state each) and the done state,
// with n the step count clamped to MAX_STEPS. The single shared multiplier
// serves both maturity walks and the node cell row the backward rounds. The
// next start is taken only once busy is low again after done, so a new option is
// not taken before the last one is through. The result appears on option_value
// and saturated for one cycle with done high; the receiver cannot stall it.
// Configuration must be written only while busy is low; the block does not
// enforce it. Prices are unsigned Q16.16, factors Q2.30 and weights Q1.30.
module binomial_tree_option_pricer_core import btop_pkg::*; #(
	parameter int MAX_STEPS        = MAX_STEPS_DEF,
	parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [31:0]           spot_price,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [31:0]           option_value,
	output logic                  saturated
);
	localparam int NN = MAX_STEPS + 1;       // node cells
	localparam int SW = $clog2(NN + 1);      // step counter width
	localparam int IW = (NN > 1) ? $clog2(NN) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DOWN = 3'd1;   // spot times down, n times
	localparam logic [2:0] ST_UP   = 3'd2;   // node i-1 = node i * up * up
	localparam logic [2:0] ST_MUL  = 3'd3;   // cell row products
	localparam logic [2:0] ST_UPD  = 3'd4;   // cell row update
	localparam logic [2:0] ST_DONE = 3'd5;

	// configuration registers
	logic [31:0] strike_q, barrier_q, up_q, down_q;
	logic [30:0] upw_q, dnw_q;
	logic [7:0]  steps_q;
	logic [3:0]  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strike_q  <= '0;
			barrier_q <= '0;
			up_q      <= 32'h4000_0000;
			down_q    <= 32'h4000_0000;
			upw_q     <= 31'h2000_0000;
			dnw_q     <= 31'h2000_0000;
			steps_q   <= 8'd1;
			mode_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_STRIKE:   strike_q  <= cfg_data;
				REG_BARRIER:  barrier_q <= cfg_data;
				REG_UP:       up_q      <= cfg_data;
				REG_DOWN:     down_q    <= cfg_data;
				REG_UP_WGT:   upw_q     <= cfg_data[30:0];
				REG_DOWN_WGT: dnw_q     <= cfg_data[30:0];
				REG_STEPS:    steps_q   <= cfg_data[7:0];
				REG_MODE:     mode_q    <= cfg_data[3:0];
				default:      ;
			endcase
		end
	end

	cell_cfg_t ccfg;
	assign ccfg = '{strike: strike_q, barrier: barrier_q, down: down_q, up_wgt: upw_q,
		down_wgt: dnw_q, put: mode_q[0], american: mode_q[1], bar: mode_q[3:2]};

	// control
	logic [2:0]    state_q;
	logic [SW-1:0] n_q;        // clamped step count of this item
	logic [SW-1:0] cnt_q;      // loop counter
	logic [1:0]    phase_q;    // cycle within a multi-cycle multiply op
	logic          sat_q;
	logic [31:0]   s_q;        // running price of the maturity walk
	logic [SW-1:0] n_clamp;

	assign n_clamp = (32'(steps_q) > 32'(MAX_STEPS)) ? SW'(MAX_STEPS) : SW'(steps_q);

	// shared multiplier for the maturity row
	logic [31:0] m_a, m_f, m_y;
	logic        m_sat;

	btop_mul #(.FACTOR_FRAC_BITS(FACTOR_FRAC_BITS)) u_mul (
		.clk(clk), .a(m_a), .f(m_f), .y(m_y), .sat(m_sat)
	);

	// during the up walk the first product feeds back for the second up step
	assign m_a = (state_q == ST_IDLE) ? spot_price : ((phase_q != 2'd0) ? m_y : s_q);
	assign m_f = (state_q == ST_UP) ? up_q : down_q;

	// node cell row, cell i takes its right neighbor value
	logic [NN-1:0]       load;
	logic [NN-1:0][31:0] cval;
	logic [NN-1:0]       csat;
	logic [31:0]         load_price;
	logic                row_mul, row_upd;

	assign row_mul = (state_q == ST_MUL);
	assign row_upd = (state_q == ST_UPD);

	genvar g;
	generate
		for (g = 0; g < NN; g++) begin : g_cell
			logic [31:0] nbr;
			if (g == NN - 1) begin : g_last
				assign nbr = '0;
			end else begin : g_mid
				assign nbr = cval[g+1];
			end
			btop_cell #(.FACTOR_FRAC_BITS(FACTOR_FRAC_BITS)) u_cell (
				.clk(clk), .cfg(ccfg), .load(load[g]), .load_price(load_price),
				.step_mul(row_mul), .step_upd(row_upd), .nbr_value(nbr),
				.value(cval[g]), .sat(csat[g])
			);
		end
	endgenerate

	// saturation only counts for cells below the active round width
	logic [NN-1:0] act_mask;
	always_comb begin
		for (int k = 0; k < NN; k++) act_mask[k] = (SW'(k) < cnt_q);
	end

	// node n is loaded as the down walk ends, each lower node after two up steps
	logic          ld_en;
	logic [IW-1:0] ld_idx;
	always_comb begin
		ld_en = 1'b0;
		ld_idx = cnt_q[IW-1:0];
		load_price = s_q;
		if (state_q == ST_DOWN && cnt_q == '0) begin
			ld_en = 1'b1;
			ld_idx = n_q[IW-1:0];
		end else if (state_q == ST_UP && phase_q == 2'd2) begin
			ld_en = 1'b1;
			ld_idx = IW'(cnt_q - SW'(1));
			load_price = m_y;
		end
		for (int k = 0; k < NN; k++) load[k] = ld_en && (ld_idx == IW'(k));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			cnt_q   <= '0;
			phase_q <= 2'd0;
			sat_q   <= 1'b0;
			s_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q     <= n_clamp;
						cnt_q   <= n_clamp;
						s_q     <= spot_price;
						sat_q   <= 1'b0;
						phase_q <= 2'd0;
						state_q <= ST_DOWN;
					end
				end
				ST_DOWN: begin
					if (cnt_q == '0) begin
						// node n loaded this cycle, start the up walk unless n is zero
						cnt_q   <= n_q;
						phase_q <= 2'd0;
						state_q <= (n_q == '0) ? ST_DONE : ST_UP;
					end else if (phase_q == 2'd0) begin
						phase_q <= 2'd1;
					end else begin
						s_q     <= m_y;
						sat_q   <= sat_q | m_sat;
						cnt_q   <= cnt_q - SW'(1);
						phase_q <= 2'd0;
					end
				end
				ST_UP: begin
					if (phase_q == 2'd0) begin
						phase_q <= 2'd1;
					end else if (phase_q == 2'd1) begin
						// first up product ready, second one being formed
						sat_q   <= sat_q | m_sat;
						phase_q <= 2'd2;
					end else begin
						// second product loads node cnt-1 this cycle
						sat_q   <= sat_q | m_sat;
						s_q     <= m_y;
						phase_q <= 2'd0;
						if (cnt_q == SW'(1)) begin
							cnt_q   <= n_q;
							state_q <= ST_MUL;
						end else begin
							cnt_q <= cnt_q - SW'(1);
						end
					end
				end
				ST_MUL: state_q <= ST_UPD;
				ST_UPD: begin
					sat_q <= sat_q | (|(csat & act_mask));
					if (cnt_q == SW'(1)) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q   <= cnt_q - SW'(1);
						state_q <= ST_MUL;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign option_value = cval[0];
	assign saturated = sat_q;

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held more than one cycle");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && state_q != ST_DONE) |=> busy) else $error("busy dropped mid item");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
endmodule

/* tb/sv/binomial_tree_option_pricer_core_tb.sv */
// self-checking testbench of the binomial lattice option pricer core
module binomial_tree_option_pricer_core_tb;
	import btop_pkg::*;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [31:0]           data;
	} pricer_req_t;

	typedef struct {
		logic [31:0] value;
		logic        sat;
	} price_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [31:0]           spot_price = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  done;
	logic [31:0]           option_value;
	logic                  saturated;

	// stimulus still to be driven, in order: register writes and spot prices
	pricer_req_t   pending_reqs[$];
	// prices expected back from the block, oldest first
	price_result_t expected_prices[$];

	// testbench copy of the option terms
	logic [31:0] strike_sh, barrier_sh, up_sh, down_sh;
	logic [30:0] up_wgt_sh, down_wgt_sh;
	logic [7:0]  steps_sh;
	logic [3:0]  mode_sh;

	int errors = 0;
	int spots_total = 0;
	int spots_accepted = 0;
	int quiet_cycles = 0;

	binomial_tree_option_pricer_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.spot_price(spot_price), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .done(done), .option_value(option_value),
		.saturated(saturated)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// lattice arithmetic
	// ---------------------------------------------------------------

	// round half up at the factor point, clip to 32 bits
	function automatic logic [31:0] round_clip(input logic [63:0] p, inout bit sat);
		logic [63:0] r;
		r = ((p >> (FACTOR_FRAC_BITS_DEF - 1)) + 64'd1) >> 1;
		if (r > 64'hFFFF_FFFF) begin
			sat = 1'b1;
			return 32'hFFFF_FFFF;
		end
		return r[31:0];
	endfunction

	function automatic logic [31:0] exercise_gain(input logic [31:0] s);
		if (mode_sh[0])
			return (strike_sh > s) ? strike_sh - s : 32'd0;
		return (s > strike_sh) ? s - strike_sh : 32'd0;
	endfunction

	// barrier code three means no barrier
	function automatic bit knocked_out(input logic [31:0] s);
		case (mode_sh[3:2])
			BAR_UP_OUT:   return s >= barrier_sh;
			BAR_DOWN_OUT: return s <= barrier_sh;
			default:      return 1'b0;
		endcase
	endfunction

	// full lattice price of one spot under the current option terms
	function automatic price_result_t price_option(input logic [31:0] spot);
		logic [31:0]   px[0:MAX_STEPS_DEF];
		logic [31:0]   vx[0:MAX_STEPS_DEF];
		logic [31:0]   s, p, v;
		logic [63:0]   acc;
		bit            sat;
		int            n;
		price_result_t res;
		sat = 1'b0;
		n = (steps_sh > MAX_STEPS_DEF) ? MAX_STEPS_DEF : steps_sh;
		// walk the spot down to the lowest maturity node
		s = spot;
		for (int i = 0; i < n; i++)
			s = round_clip(64'(s) * 64'(down_sh), sat);
		px[n] = s;
		// each higher node is two up moves above the one below
		for (int i = n; i > 0; i--) begin
			s = round_clip(64'(px[i]) * 64'(up_sh), sat);
			px[i-1] = round_clip(64'(s) * 64'(up_sh), sat);
		end
		for (int i = 0; i <= n; i++)
			vx[i] = knocked_out(px[i]) ? 32'd0 : exercise_gain(px[i]);
		// backward induction
		for (int j = n; j > 0; j--) begin
			for (int i = 0; i < j; i++) begin
				p = round_clip(64'(px[i]) * 64'(down_sh), sat);
				px[i] = p;
				if (knocked_out(p)) begin
					v = 32'd0;
				end else begin
					acc = 64'(up_wgt_sh) * 64'(vx[i]) + 64'(down_wgt_sh) * 64'(vx[i+1]);
					v = round_clip(acc, sat);
					if (mode_sh[1] && exercise_gain(p) > v)
						v = exercise_gain(p);
				end
				vx[i] = v;
			end
		end
		res.value = vx[0];
		res.sat = sat;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------

	task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		pending_reqs.push_back('{1'b1, idx, data});
	endtask

	task automatic add_spot(input logic [31:0] s);
		pending_reqs.push_back('{1'b0, '0, s});
		spots_total++;
	endtask

	// unused upper bits of the narrow registers carry random junk
	task automatic add_terms(input logic [31:0] k, input logic [31:0] b,
			input logic [31:0] u, input logic [31:0] d, input logic [30:0] wu,
			input logic [30:0] wd, input logic [7:0] n, input logic [3:0] m);
		add_reg(REG_STRIKE, k);
		add_reg(REG_BARRIER, b);
		add_reg(REG_UP, u);
		add_reg(REG_DOWN, d);
		add_reg(REG_UP_WGT, {1'($urandom_range(1)), wu});
		add_reg(REG_DOWN_WGT, {1'($urandom_range(1)), wd});
		add_reg(REG_STEPS, {24'($urandom() >> 8), n});
		add_reg(REG_MODE, {28'($urandom() >> 4), m});
	endtask

	task automatic build_random_phase();
		logic [31:0] k, b, u, d, scale;
		logic [30:0] wu, wd;
		logic [7:0]  n;
		int          sel, cnt;
		scale = $urandom() >> $urandom_range(0, 16);
		k = scale;
		b = scale + ($urandom_range(0, 2) == 0 ? -(scale >> 3) : (scale >> 3));
		if ($urandom_range(9) == 0) b = $urandom();
		if ($urandom_range(9) == 0) begin
			// wild factors push the walks into saturation
			u = $urandom();
			d = $urandom();
		end else begin
			u = 32'h4000_0000 + $urandom_range(0, 32'h0800_0000);
			d = 32'((64'h1 << 60) / 64'(u));
		end
		wu = 31'($urandom_range(0, 32'h4000_0000));
		wd = ($urandom_range(1) == 0) ? 31'($urandom_range(0, 32'h4000_0000))
			: 31'(32'h3F00_0000 - wu[29:0]);
		sel = $urandom_range(99);
		if (sel < 3) begin
			n = 8'd255;
			cnt = 2;
		end else if (sel < 12) begin
			n = 8'($urandom_range(8, 40));
			cnt = 8;
		end else begin
			n = 8'($urandom_range(0, 6));
			cnt = $urandom_range(15, 40);
		end
		add_terms(k, b, u, d, wu, wd, n, 4'($urandom_range(0, 15)));
		for (int i = 0; i < cnt; i++) begin
			case ($urandom_range(5))
				0:       add_spot($urandom());
				1:       add_spot(32'hFFFF_FFFF);
				2:       add_spot(b + $urandom_range(0, 4) - 2);
				default: add_spot(scale + ($urandom() >> $urandom_range(1, 31)) - (scale >> 4));
			endcase
		end
	endtask

	initial begin
		// reset values of the option terms, nothing written yet
		add_spot(32'd0);
		add_spot(32'hFFFF_FFFF);
		add_spot(32'h0001_0000);
		// zero steps: the spot itself is priced, every mode incl. barrier code three
		for (int m = 0; m < 16; m++) begin
			add_terms(32'h0010_0000, 32'h0012_0000, 32'h4000_0000, 32'h4000_0000,
				31'h2000_0000, 31'h2000_0000, 8'd0, 4'(m));
			add_spot(32'h0014_0000);
		end
		// extreme factors and weights, deep saturation
		add_terms(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			31'h4000_0000, 31'h4000_0000, 8'd3, 4'd0);
		add_spot(32'hFFFF_FFFF);
		add_terms(32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 31'd0, 8'd1, 4'd11);
		add_spot(32'd0);
		while (spots_total < 1800)
			build_random_phase();
	end

	// ---------------------------------------------------------------
	// driver
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			cfg_idx <= '0;
			cfg_data <= '0;
			spot_price <= '0;
			strike_sh <= '0;
			barrier_sh <= '0;
			up_sh <= 32'h4000_0000;
			down_sh <= 32'h4000_0000;
			up_wgt_sh <= 31'h2000_0000;
			down_wgt_sh <= 31'h2000_0000;
			steps_sh <= 8'd1;
			mode_sh <= 4'd0;
		end else begin : drive
			logic        start_nxt;
			logic        we_nxt;
			int          idle_pct;
			pricer_req_t r;
			start_nxt = start;
			we_nxt = 1'b0;
			idle_pct = (spots_accepted < spots_total / 3) ? 35
				: (spots_accepted < 2 * spots_total / 3) ? 65 : 0;
			quiet_cycles = done ? 0 : quiet_cycles + 1;
			// item taken at this edge: price it under the terms now in force
			if (start && !busy) begin
				expected_prices.push_back(price_option(spot_price));
				void'(pending_reqs.pop_front());
				spots_accepted++;
				start_nxt = 1'b0;
			end
			if (!start_nxt && pending_reqs.size() > 0) begin
				r = pending_reqs[0];
				if (r.is_cfg) begin
					// only touch the terms once the block has gone quiet
					if (expected_prices.size() == 0 && !busy && quiet_cycles >= 8) begin
						we_nxt = 1'b1;
						cfg_idx <= r.idx;
						cfg_data <= r.data;
						void'(pending_reqs.pop_front());
						case (r.idx)
							REG_STRIKE:   strike_sh <= r.data;
							REG_BARRIER:  barrier_sh <= r.data;
							REG_UP:       up_sh <= r.data;
							REG_DOWN:     down_sh <= r.data;
							REG_UP_WGT:   up_wgt_sh <= r.data[30:0];
							REG_DOWN_WGT: down_wgt_sh <= r.data[30:0];
							REG_STEPS:    steps_sh <= r.data[7:0];
							REG_MODE:     mode_sh <= r.data[3:0];
						endcase
					end
				end else if ($urandom_range(99) >= idle_pct) begin
					start_nxt = 1'b1;
					spot_price <= r.data;
				end
			end
			start <= start_nxt;
			cfg_we <= we_nxt;
		end
	end

	// ---------------------------------------------------------------
	// monitor: every done strobe must match the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_prices.size() == 0) begin
				$display("%0t: unexpected result value=%h sat=%b", $time, option_value, saturated);
				errors++;
			end else begin : cmp
				price_result_t e;
				e = expected_prices.pop_front();
				if (option_value !== e.value) begin
					$display("%0t: option_value expected %h actual %h", $time, e.value, option_value);
					errors++;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, e.sat, saturated);
					errors++;
				end
			end
		end
	end

	// reset, then wait for all items to drain
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_reqs.size() > 0 || expected_prices.size() > 0 || start)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hang guard
	initial begin
		#8000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/btop_pkg.sv
rtl/btop_mul.sv
rtl/btop_cell.sv
rtl/binomial_tree_option_pricer_core.sv
tb/sv/binomial_tree_option_pricer_core_tb.sv
